// ===== sv/rqsc_pkg.sv =====
// Package for the rotary quadrature step counter.
// Holds the decode tables, register indexes, event codes and field widths.
// No dependencies.
package rqsc_pkg;

  // Field widths
  localparam int unsigned PosW     = 16;
  localparam int unsigned RowW     = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegHalfStep = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinPos   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxPos   = 2'd2;

  // Step event codes; the table mark bits use the same encoding
  localparam logic [1:0] EvNone = 2'd0;
  localparam logic [1:0] EvCw   = 2'd1;
  localparam logic [1:0] EvCcw  = 2'd2;

  localparam logic [RowW-1:0] RowStart = 3'd0;
  localparam logic [RowW-1:0] RowUnused = 3'd7;

  // Table entry: bits [5:4] event mark, bits [2:0] next row
  typedef logic [5:0] tab_entry_t;

  typedef struct packed {
    logic [1:0]      mark;
    logic [RowW-1:0] next_row;
  } step_t;

  // Full-step table, indexed [row][col], col = {pin_b, pin_a}
  localparam tab_entry_t FullTab [8][4] = '{
    '{6'h00, 6'h02, 6'h04, 6'h00},
    '{6'h03, 6'h00, 6'h01, 6'h10},
    '{6'h03, 6'h02, 6'h00, 6'h00},
    '{6'h03, 6'h02, 6'h01, 6'h00},
    '{6'h06, 6'h00, 6'h04, 6'h00},
    '{6'h06, 6'h05, 6'h00, 6'h20},
    '{6'h06, 6'h05, 6'h04, 6'h00},
    '{6'h00, 6'h00, 6'h00, 6'h00}
  };

  // Half-step table, emits at codes 00 and 11
  localparam tab_entry_t HalfTab [8][4] = '{
    '{6'h03, 6'h02, 6'h01, 6'h00},
    '{6'h23, 6'h00, 6'h01, 6'h00},
    '{6'h13, 6'h02, 6'h00, 6'h00},
    '{6'h03, 6'h05, 6'h04, 6'h00},
    '{6'h03, 6'h03, 6'h04, 6'h10},
    '{6'h03, 6'h05, 6'h03, 6'h20},
    '{6'h00, 6'h00, 6'h00, 6'h00},
    '{6'h00, 6'h00, 6'h00, 6'h00}
  };

  // Look up one table step
  function automatic step_t table_step(input logic half, input logic [RowW-1:0] row,
                                       input logic [1:0] col);
    tab_entry_t e;
    step_t      s;
    e = half ? HalfTab[row][col] : FullTab[row][col];
    s.mark     = e[5:4];
    s.next_row = e[2:0];
    return s;
  endfunction

endpackage

// ===== sv/rotary_quadrature_step_counter_top.sv =====
// Top level of the rotary quadrature step counter.
// Depends on rqsc_pkg for the decode tables, codes and widths.
//
// Usage:
//   The slave stream takes one sample of the encoder pins per beat. Each
//   sample steps a table decoder (seven states in full-step mode, six in
//   half-step mode) that filters contact bounce; a completed clockwise
//   step raises the position counter and a counterclockwise step lowers it,
//   wrapping between the configured minimum and maximum.
//   The master stream gives exactly one beat per sample: the counter after
//   that sample and the step event.
//   The result of an accepted sample is registered and is on the master side
//   in the next cycle. Throughput is one sample per cycle while the receiver
//   takes each beat; the table lookup and the counter add/compare sit between
//   the decoder state and the result register.
//   When the receiver stalls, the result register holds its beat and
//   s_axis_tready drops; a sample is still taken in the cycle the held beat
//   leaves.
//   Reset puts the decoder in its start state, clears the counter and the
//   output valid, and loads the register defaults (full-step, full range).
//   Write configuration only while no beat is in flight.
module rotary_quadrature_step_counter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [rqsc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [rqsc_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // Sample stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rqsc_pkg::InDataW-1:0]      s_axis_tdata,  // [0] pin_a, [1] pin_b, rest zero
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rqsc_pkg::OutDataW-1:0]     m_axis_tdata   // [15:0] position, [17:16] step_event
);
  import rqsc_pkg::*;

  // Configuration registers
  logic                   half_step_q;
  logic signed [PosW-1:0] min_pos_q;
  logic signed [PosW-1:0] max_pos_q;

  // Decoder and counter state
  logic [RowW-1:0]        row_q, row_d;
  logic signed [PosW-1:0] count_q, count_d;

  // Result register
  logic                   out_valid_q, out_valid_d;
  logic signed [PosW-1:0] out_pos_q;
  logic [1:0]             out_ev_q;

  logic                   in_fire;
  logic                   pin_a;
  logic                   pin_b;
  step_t                  step;
  logic signed [PosW:0]   count_ext;
  logic signed [PosW:0]   count_step;
  logic signed [PosW:0]   min_ext;
  logic signed [PosW:0]   max_ext;
  logic [1:0]             ev_d;

  assign pin_a = s_axis_tdata[0];
  assign pin_b = s_axis_tdata[1];

  // Take a sample whenever the result register is empty or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Decode the sample against the current row
  assign step = table_step(half_step_q, row_q, {pin_b, pin_a});

  // Step the counter with wraparound at the limits
  assign count_ext = {count_q[PosW-1], count_q};
  assign min_ext   = {min_pos_q[PosW-1], min_pos_q};
  assign max_ext   = {max_pos_q[PosW-1], max_pos_q};

  always_comb begin
    count_step = count_ext;
    ev_d       = EvNone;
    case (step.mark)
      EvCw: begin
        count_step = count_ext + 17'sd1;
        ev_d       = EvCw;
      end
      EvCcw: begin
        count_step = count_ext - 17'sd1;
        ev_d       = EvCcw;
      end
      default: begin
        count_step = count_ext;
        ev_d       = EvNone;
      end
    endcase
  end

  always_comb begin
    row_d   = row_q;
    count_d = count_q;
    if (in_fire) begin
      row_d = step.next_row;
      if (ev_d != EvNone) begin
        if (count_step > max_ext) begin
          count_d = min_pos_q;
        end else if (count_step < min_ext) begin
          count_d = max_pos_q;
        end else begin
          count_d = count_step[PosW-1:0];
        end
      end
    end
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_step_q <= 1'b0;
      min_pos_q   <= 16'sh8000;
      max_pos_q   <= 16'sh7fff;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegHalfStep: half_step_q <= cfg_wdata_i[0];
        RegMinPos:   min_pos_q   <= cfg_wdata_i;
        RegMaxPos:   max_pos_q   <= cfg_wdata_i;
        default: begin
          half_step_q <= half_step_q;
        end
      endcase
    end
  end

  // Decoder state, counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= RowStart;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      row_q       <= row_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_pos_q <= count_d;
      out_ev_q  <= ev_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_ev_q, out_pos_q};

`ifndef SYNTHESIS
  // The unused row is never reached
  assert property (@(posedge clk_i) disable iff (!rst_ni) row_q != RowUnused)
    else $error("decoder entered unused row");

  // A held result never carries the reserved event code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   m_axis_tvalid |-> (out_ev_q == EvNone || out_ev_q == EvCw ||
                                      out_ev_q == EvCcw))
    else $error("reserved step event code on output");

  // A result without a step shows the live counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (m_axis_tvalid && out_ev_q == EvNone) |-> out_pos_q == count_q)
    else $error("no-step result disagrees with counter");

  // Counter only moves on an accepted sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !in_fire |=> $stable(count_q))
    else $error("counter changed without a sample");
`endif

endmodule
